@@ hw/rtl/ppb_pkg.sv @@
// Package for the ping-pong buffer controller.
// Holds parameter defaults, field widths and status codes.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package ppb_pkg;

    // Parameter defaults.
    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 32;

    // Fixed field widths of the stream channels.
    localparam int WORD_W   = 32;
    localparam int STATUS_W = 2;
    localparam int OUT_USER_W = STATUS_W + 1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    // Operation codes carried in the input tuser.
    localparam logic OP_PRODUCE = 1'b0;
    localparam logic OP_CONSUME = 1'b1;

endpackage

@@ hw/rtl/ppb_bank_ram.sv @@
// Simple dual-port bank memory with one write and one registered read port.
// Depends on ppb_pkg for parameter defaults.
`timescale 1ns / 1ps

module ppb_bank_ram #(
    parameter int WORDS      = 2 * ppb_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = ppb_pkg::DATA_WIDTH_DEF,
    parameter int ADDR_W     = $clog2(WORDS)
) (
    input  logic                  i_clk,
    input  logic                  i_wr_en,
    input  logic [ADDR_W-1:0]     i_wr_addr,
    input  logic [DATA_WIDTH-1:0] i_wr_data,
    input  logic                  i_rd_en,
    input  logic [ADDR_W-1:0]     i_rd_addr,
    output logic [DATA_WIDTH-1:0] o_rd_data
);
    import ppb_pkg::*;

    logic [DATA_WIDTH-1:0] r_mem [WORDS];
    logic [DATA_WIDTH-1:0] r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ hw/rtl/ping_pong_buffer_controller_top.sv @@
// Top level of the ping-pong buffer controller.
// Depends on ppb_pkg and instantiates ppb_bank_ram.
`timescale 1ns / 1ps

// Ping-pong double buffer with two banks of DEPTH words held in one memory of
// 2*DEPTH entries. Each input transaction is one access: tuser selects produce
// (write tdata into the produce bank) or consume (read the next word of the
// consume bank), and every input transaction yields exactly one output
// transaction carrying the read word, a status code and a swap flag. A produce
// into a full bank or a consume from a drained bank is refused with a status
// code and changes nothing. When the produce bank is full and the consume bank
// is drained the banks swap roles. A produce or refused item is done when taken;
// an accepted consume waits in S_READ for the registered bank memory read. A new
// item is taken once the controller is idle and the output register is empty
// or being emptied in the same cycle. The memory needs no clearing after reset,
// since a bank is read only after it has been written in full.
module ping_pong_buffer_controller_top #(
    parameter int DEPTH      = ppb_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = ppb_pkg::DATA_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Input stream.
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [ppb_pkg::WORD_W-1:0]      i_s_tdata,  // [31:0] write_data
    input  logic                            i_s_tuser,  // [0] op
    // Output stream.
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [ppb_pkg::WORD_W-1:0]      o_m_tdata,  // [31:0] read_data
    output logic [ppb_pkg::OUT_USER_W-1:0]  o_m_tuser   // [1:0] status, [2] swapped
);
    import ppb_pkg::*;

    localparam int WORDS  = 2 * DEPTH;
    localparam int ADDR_W = $clog2(WORDS);
    localparam int LVL_W  = $clog2(DEPTH + 1);
    localparam logic [LVL_W-1:0]  LVL_FULL = LVL_W'(DEPTH);
    localparam logic [ADDR_W-1:0] BANK_OFS = ADDR_W'(DEPTH);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_READ = 2'b10
    } t_state;

    t_state r_state, n_state;

    logic             r_consume_bank, n_consume_bank;
    logic [LVL_W-1:0] r_produce_level, n_produce_level;
    logic [LVL_W-1:0] r_consume_level, n_consume_level;
    logic             r_pend_swapped, n_pend_swapped;

    logic                  r_out_valid, n_out_valid;
    logic [WORD_W-1:0]     r_out_data, n_out_data;
    logic [STATUS_W-1:0]   r_out_status, n_out_status;
    logic                  r_out_swapped, n_out_swapped;

    logic                  w_accept;
    logic                  w_out_free;
    logic                  w_wr_en;
    logic                  w_rd_en;
    logic [ADDR_W-1:0]     w_wr_addr;
    logic [ADDR_W-1:0]     w_rd_addr;
    logic [DATA_WIDTH-1:0] w_wr_word;
    logic [DATA_WIDTH-1:0] w_rd_word;
    logic [WORD_W-1:0]     w_rd_ext;

    // Bank memory.
    ppb_bank_ram #(
        .WORDS      (WORDS),
        .DATA_WIDTH (DATA_WIDTH),
        .ADDR_W     (ADDR_W)
    ) u_bank_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_word),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_word)
    );

    // The stored word keeps the low DATA_WIDTH bits of the input word, zero-extended if wider.
    generate
        if (DATA_WIDTH <= WORD_W) begin : g_wr_narrow
            assign w_wr_word = i_s_tdata[DATA_WIDTH-1:0];
        end else begin : g_wr_wide
            assign w_wr_word = {{(DATA_WIDTH-WORD_W){1'b0}}, i_s_tdata};
        end
    endgenerate

    // A read word is sign-extended from DATA_WIDTH bits into the output field, or cut if wider.
    generate
        if (DATA_WIDTH >= WORD_W) begin : g_rd_wide
            assign w_rd_ext = w_rd_word[WORD_W-1:0];
        end else begin : g_rd_narrow
            assign w_rd_ext = {{(WORD_W-DATA_WIDTH){w_rd_word[DATA_WIDTH-1]}}, w_rd_word};
        end
    endgenerate

    // Handshakes: take an item only when the output register can hold its result.
    assign w_out_free = !r_out_valid || i_m_tready;
    assign o_s_tready = (r_state == S_IDLE) && w_out_free;
    assign w_accept   = i_s_tvalid && o_s_tready;

    // Memory addresses: bank b starts at entry b*DEPTH.
    assign w_wr_addr = (r_consume_bank ? ADDR_W'(0) : BANK_OFS) + ADDR_W'(r_produce_level);
    assign w_rd_addr = (r_consume_bank ? BANK_OFS : ADDR_W'(0)) + ADDR_W'(r_consume_level);
    assign w_wr_en   = w_accept && (i_s_tuser == OP_PRODUCE) && (r_produce_level != LVL_FULL);
    assign w_rd_en   = w_accept && (i_s_tuser == OP_CONSUME) && (r_consume_level != LVL_FULL);

    // Access control, level bookkeeping and bank swap.
    always_comb begin
        n_state         = r_state;
        n_consume_bank  = r_consume_bank;
        n_produce_level = r_produce_level;
        n_consume_level = r_consume_level;
        n_pend_swapped  = r_pend_swapped;
        n_out_valid     = r_out_valid && !i_m_tready;
        n_out_data      = r_out_data;
        n_out_status    = r_out_status;
        n_out_swapped   = r_out_swapped;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_s_tuser == OP_PRODUCE) begin
                        n_out_valid  = 1'b1;
                        n_out_data   = '0;
                        if (r_produce_level == LVL_FULL) begin
                            n_out_status  = ST_FULL;
                            n_out_swapped = 1'b0;
                        end else begin
                            n_out_status = ST_OK;
                            if ((r_produce_level + LVL_W'(1) == LVL_FULL)
                                && (r_consume_level == LVL_FULL)) begin
                                n_consume_bank  = !r_consume_bank;
                                n_produce_level = '0;
                                n_consume_level = '0;
                                n_out_swapped   = 1'b1;
                            end else begin
                                n_produce_level = r_produce_level + LVL_W'(1);
                                n_out_swapped   = 1'b0;
                            end
                        end
                    end else begin
                        if (r_consume_level == LVL_FULL) begin
                            n_out_valid   = 1'b1;
                            n_out_data    = '0;
                            n_out_status  = ST_EMPTY;
                            n_out_swapped = 1'b0;
                        end else begin
                            // Result waits for the memory read.
                            n_state = S_READ;
                            if ((r_consume_level + LVL_W'(1) == LVL_FULL)
                                && (r_produce_level == LVL_FULL)) begin
                                n_consume_bank  = !r_consume_bank;
                                n_produce_level = '0;
                                n_consume_level = '0;
                                n_pend_swapped  = 1'b1;
                            end else begin
                                n_consume_level = r_consume_level + LVL_W'(1);
                                n_pend_swapped  = 1'b0;
                            end
                        end
                    end
                end
            end
            S_READ: begin
                // The output register was freed when the consume was taken.
                n_state       = S_IDLE;
                n_out_valid   = 1'b1;
                n_out_data    = w_rd_ext;
                n_out_status  = ST_OK;
                n_out_swapped = r_pend_swapped;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_consume_bank  <= 1'b0;
            r_produce_level <= '0;
            r_consume_level <= LVL_FULL;
            r_out_valid     <= 1'b0;
        end else begin
            r_state         <= n_state;
            r_consume_bank  <= n_consume_bank;
            r_produce_level <= n_produce_level;
            r_consume_level <= n_consume_level;
            r_out_valid     <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_pend_swapped <= n_pend_swapped;
        r_out_data     <= n_out_data;
        r_out_status   <= n_out_status;
        r_out_swapped  <= n_out_swapped;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = {r_out_swapped, r_out_status};

endmodule
